// File: rtl/bitrate_meter_hysteresis_switch_defines.svh
// Assertion macros shared by the bit-rate meter RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef BITRATE_METER_HYSTERESIS_SWITCH_DEFINES_SVH
`define BITRATE_METER_HYSTERESIS_SWITCH_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BRM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/brm_pkg.sv
// Shared types, widths and constants of the bit-rate meter.
// No dependencies; imported by brm_mul, brm_div, brm_hyst and the top level.
package brm_pkg;

  localparam int unsigned SEQ_W    = 16;
  localparam int unsigned TS_W     = 32;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned FMT_W    = 8;
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned TGT_W    = 20;
  localparam int unsigned HOLD_W   = 4;
  localparam int unsigned STREAK_W = 4;
  localparam int unsigned BYTES_W  = 32;

  // rate = bytes * 5625 / (elapsed * 8)
  localparam int unsigned        MUL_K_W   = 13;
  localparam logic [MUL_K_W-1:0] RATE_NUM  = 13'd5625;
  localparam int unsigned        NUM_W     = BYTES_W + MUL_K_W;
  localparam int unsigned        DEN_SHIFT = 3;
  localparam int unsigned        DEN_W     = TS_W + DEN_SHIFT;

  localparam int unsigned MUL_DIGIT_W = 2;
  localparam int unsigned MUL_STEPS   = BYTES_W / MUL_DIGIT_W;
  localparam int unsigned DIV_STEPS   = RATE_W;

  localparam logic [TS_W-1:0]     WINDOW_TICKS = 32'd90000;
  localparam logic [HOLD_W-1:0]   HOLD_RESET   = 4'd5;
  localparam logic [STREAK_W-1:0] STREAK_MAX   = '1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET   = 2'd0,
    CFG_LINE_FMT = 2'd1,
    CFG_HOLD     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_num;
    logic [TS_W-1:0]  timestamp;
    logic [LEN_W-1:0] payload_len;
    logic [FMT_W-1:0] payload_format;
  } in_item_t;

  typedef struct packed {
    logic              duplicate;
    logic              rate_valid;
    logic [RATE_W-1:0] rate_kbps;
    logic              active;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } brm_state_e;

  typedef struct packed {
    logic calc;
    logic commit;
  } hyst_ctrl_t;

endpackage

// File: rtl/brm_stream_if.sv
// Valid/ready channel carrying one payload beat per handshake.
// Payload type is set per instance (input, result and config channels).
interface brm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/brm_mul.sv
// Radix-4 serial multiplier: byte count times the fixed rate numerator.
// Depends on brm_pkg.
module brm_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [brm_pkg::BYTES_W-1:0] operand_i,
  output logic                       done_o,
  output logic [brm_pkg::NUM_W-1:0]  product_o
);
  import brm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_STEPS);
  localparam int unsigned SUM_W = MUL_K_W + MUL_DIGIT_W;

  function automatic logic [SUM_W-1:0] digit_mult(input logic [MUL_DIGIT_W-1:0] d);
    logic [SUM_W-1:0] k;
    logic [SUM_W-1:0] r;
    k = SUM_W'(RATE_NUM);
    r = '0;
    for (int i = 0; i < MUL_DIGIT_W; i++) begin
      if (d[i]) r = r + (k << i);
    end
    return r;
  endfunction

  logic [NUM_W-1:0] prod_q, prod_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [SUM_W-1:0] sum;

  // high part stays below the constant, so the sum never overflows SUM_W
  assign sum = SUM_W'(prod_q[NUM_W-1:BYTES_W]) + digit_mult(prod_q[MUL_DIGIT_W-1:0]);

  always_comb begin
    prod_d = prod_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      prod_d = {MUL_K_W'(0), operand_i};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      prod_d = {sum, prod_q[BYTES_W-1:MUL_DIGIT_W]};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign done_o    = done_q;
  assign product_o = prod_q;

endmodule

// File: rtl/brm_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on brm_pkg and the assertion macro header.
`include "bitrate_meter_hysteresis_switch_defines.svh"

module brm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [brm_pkg::NUM_W-1:0]  num_i,
  input  logic [brm_pkg::DEN_W-1:0]  den_i,
  output logic                       done_o,
  output logic [brm_pkg::RATE_W-1:0] quot_o
);
  import brm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [RATE_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W+1:0]  diff;
  logic              ge;

  // numerator low bits shift out of quo_q as quotient bits shift in
  assign rem_sh = {rem_q, quo_q[RATE_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge     = !diff[DEN_W+1];

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // quotient fits RATE_W bits, so the upper numerator bits are below den
      rem_d  = DEN_W'(num_i[NUM_W-1:RATE_W]);
      quo_d  = num_i[RATE_W-1:0];
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_d = {quo_q[RATE_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  `BRM_ASSERT_IMP(a_div_rem_below_den, busy_q, rem_q < den_q, "divider remainder not below divisor")
  `BRM_ASSERT_IMP(a_div_start_idle, start_i, !busy_q, "divider restarted while busy")

endmodule

// File: rtl/brm_hyst.sv
// Hysteresis switch: threshold and format compare, saturating streak, active flag.
// Depends on brm_pkg.
module brm_hyst (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  brm_pkg::hyst_ctrl_t        ctrl_i,
  input  logic [brm_pkg::RATE_W-1:0] rate_i,
  input  logic [brm_pkg::FMT_W-1:0]  fmt_i,
  input  logic [brm_pkg::TGT_W-1:0]  target_i,
  input  logic [brm_pkg::FMT_W-1:0]  line_fmt_i,
  input  logic [brm_pkg::HOLD_W-1:0] hold_i,
  output logic                       active_o
);
  import brm_pkg::*;

  localparam int unsigned R10_W = RATE_W + 4;
  localparam int unsigned THR_W = TGT_W + 4;

  logic [R10_W-1:0]    r10_q, r10_d;
  logic [THR_W-1:0]    thr_q, thr_d;
  logic                mis_q, mis_d;
  logic [STREAK_W-1:0] streak_q, streak_d, streak_nxt;
  logic                active_q, active_d;
  logic [THR_W-1:0]    t9, t11;
  logic                hit;

  // calc beat: rate*10 against target*9 (active) or target*11 (idle)
  assign t9  = (THR_W'(target_i) << 3) + THR_W'(target_i);
  assign t11 = t9 + (THR_W'(target_i) << 1);

  assign hit = active_q ? (r10_q <= R10_W'(thr_q)) : (r10_q >= R10_W'(thr_q));
  assign streak_nxt = !hit ? '0 :
                      (streak_q == STREAK_MAX) ? streak_q : streak_q + STREAK_W'(1);

  always_comb begin
    r10_d    = r10_q;
    thr_d    = thr_q;
    mis_d    = mis_q;
    streak_d = streak_q;
    active_d = active_q;
    if (ctrl_i.calc) begin
      r10_d = (R10_W'(rate_i) << 3) + (R10_W'(rate_i) << 1);
      thr_d = active_q ? t9 : t11;
      mis_d = (fmt_i != line_fmt_i);
    end
    if (ctrl_i.commit) begin
      if (mis_q) begin
        active_d = 1'b1;
      end else begin
        streak_d = streak_nxt;
        if (streak_nxt >= hold_i) active_d = !active_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      streak_q <= '0;
      active_q <= 1'b0;
    end else begin
      streak_q <= streak_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r10_q <= r10_d;
    thr_q <= thr_d;
    mis_q <= mis_d;
  end

  assign active_o = active_q;

endmodule

// File: rtl/bitrate_meter_hysteresis_switch.sv
// Bit-rate meter with hysteresis switch, top level.
// Depends on brm_pkg, brm_stream_if, brm_mul, brm_div, brm_hyst and the macro header.
//
// Usage:
//   in_i  carries one packet descriptor per beat (seq, 90 kHz stamp, length, format).
//   out_o returns exactly one result beat per input beat, in order.
//   cfg_i writes target_kbps (index 0), line_format (1) and hold_count (2); it is
//   always ready and must only be used while no packet is in flight.
// Timing:
//   One packet is processed at a time. A duplicate, or a packet that does not close
//   the one-second window, goes from acceptance through ST_DONE into the output
//   register. A packet that closes the window runs the radix-4 serial multiplier
//   (ST_MUL) and the bit-serial divider (ST_DIV), then, for a nonzero rate, the
//   switch update (ST_EVAL) before ST_DONE. The next packet is taken in the
//   cycle after the result is registered.
// Reset:
//   Clears the window, duplicate history, streak, active flag and registers
//   (hold_count comes up as 5). No clearing pass.
// Stall:
//   A held result sits in the output register; the block finishes the next packet
//   and waits with it until the output register frees up.
`include "bitrate_meter_hysteresis_switch_defines.svh"

module bitrate_meter_hysteresis_switch (
  input  logic         clk_i,
  input  logic         rst_ni,
  brm_stream_if.sink   in_i,
  brm_stream_if.source out_o,
  brm_stream_if.sink   cfg_i
);
  import brm_pkg::*;

  brm_state_e state_q, state_d;

  logic [TGT_W-1:0]  tgt_q;
  logic [FMT_W-1:0]  line_fmt_q;
  logic [HOLD_W-1:0] hold_q;

  logic [SEQ_W-1:0]   prev_seq_q, prev_seq_d;
  logic [TS_W-1:0]    prev_stamp_q, prev_stamp_d;
  logic [TS_W-1:0]    win_start_q, win_start_d;
  logic [TS_W-1:0]    win_end_q, win_end_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;

  logic [TS_W-1:0]   elapsed_q, elapsed_d;
  logic [FMT_W-1:0]  fmt_q, fmt_d;
  logic [RATE_W-1:0] rate_q, rate_d;
  logic              rv_q, rv_d;
  logic              dup_q, dup_d;

  out_item_t out_q;
  logic      out_vld_q;
  logic      out_load;

  in_item_t   item;
  cfg_wr_t    cfg_wr;
  logic       is_dup;
  logic [TS_W-1:0]    elapsed;
  logic               win_close;
  logic [BYTES_W:0]   byte_sum;
  logic [BYTES_W-1:0] bytes_sat;

  logic               mul_start, mul_done;
  logic [NUM_W-1:0]   mul_prod;
  logic               div_start, div_done;
  logic [RATE_W-1:0]  div_quot;
  hyst_ctrl_t         hyst_ctrl;
  logic               active;
  logic               in_acc;
  logic               rate_nz;

  assign item   = in_i.payload;
  assign cfg_wr = cfg_i.payload;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign is_dup    = (item.seq_num == prev_seq_q) && (item.timestamp == prev_stamp_q);
  assign elapsed   = win_end_q - win_start_q;
  assign win_close = (win_start_q != '0) && (win_end_q != '0) && (elapsed > WINDOW_TICKS);
  assign byte_sum  = {1'b0, bytes_q} + (BYTES_W + 1)'(item.payload_len);
  assign bytes_sat = byte_sum[BYTES_W] ? '1 : byte_sum[BYTES_W-1:0];

  assign out_load = (state_q == ST_DONE) && (!out_vld_q || out_o.ready);

  always_comb begin
    state_d      = state_q;
    prev_seq_d   = prev_seq_q;
    prev_stamp_d = prev_stamp_q;
    win_start_d  = win_start_q;
    win_end_d    = win_end_q;
    bytes_d      = bytes_q;
    elapsed_d    = elapsed_q;
    fmt_d        = fmt_q;
    rate_d       = rate_q;
    rv_d         = rv_q;
    dup_d        = dup_q;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    hyst_ctrl    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          rate_d = '0;
          rv_d   = 1'b0;
          dup_d  = is_dup;
          if (is_dup) begin
            state_d = ST_DONE;
          end else begin
            prev_seq_d   = item.seq_num;
            prev_stamp_d = item.timestamp;
            win_end_d    = item.timestamp;
            if (win_close) begin
              // multiplier samples the old byte count at this edge
              mul_start   = 1'b1;
              elapsed_d   = elapsed;
              fmt_d       = item.payload_format;
              bytes_d     = BYTES_W'(item.payload_len);
              win_start_d = item.timestamp;
              state_d     = ST_MUL;
            end else begin
              bytes_d = bytes_sat;
              if (win_start_q == '0) win_start_d = item.timestamp;
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_quot != '0) begin
            rate_d         = div_quot;
            rv_d           = 1'b1;
            hyst_ctrl.calc = 1'b1;
            state_d        = ST_EVAL;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_EVAL: begin
        hyst_ctrl.commit = 1'b1;
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prev_seq_q   <= '0;
      prev_stamp_q <= '0;
      win_start_q  <= '0;
      win_end_q    <= '0;
      bytes_q      <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      prev_seq_q   <= prev_seq_d;
      prev_stamp_q <= prev_stamp_d;
      win_start_q  <= win_start_d;
      win_end_q    <= win_end_d;
      bytes_q      <= bytes_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
    fmt_q     <= fmt_d;
    rate_q    <= rate_d;
    rv_q      <= rv_d;
    dup_q     <= dup_d;
    if (out_load) begin
      out_q.duplicate  <= dup_q;
      out_q.rate_valid <= rv_q;
      out_q.rate_kbps  <= rate_q;
      out_q.active     <= active;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q      <= '0;
      line_fmt_q <= '0;
      hold_q     <= HOLD_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_wr.index)
        CFG_TARGET:   tgt_q      <= cfg_wr.data[TGT_W-1:0];
        CFG_LINE_FMT: line_fmt_q <= cfg_wr.data[FMT_W-1:0];
        CFG_HOLD:     hold_q     <= cfg_wr.data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  brm_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .operand_i (bytes_q),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  brm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_prod),
    .den_i   ({elapsed_q, {DEN_SHIFT{1'b0}}}),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  brm_hyst u_hyst (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (hyst_ctrl),
    .rate_i     (div_quot),
    .fmt_i      (fmt_q),
    .target_i   (tgt_q),
    .line_fmt_i (line_fmt_q),
    .hold_i     (hold_q),
    .active_o   (active)
  );

  assign in_acc  = in_i.valid && in_i.ready;
  assign rate_nz = (out_q.rate_kbps != '0);

  `BRM_ASSERT_IMP(a_rate_flag_match, out_vld_q, out_q.rate_valid == rate_nz, "rate flag mismatch")
  `BRM_ASSERT_IMP(a_dup_no_rate, out_vld_q && out_q.duplicate, !out_q.rate_valid, "dup with rate")
  `BRM_ASSERT_NEXT(a_one_in_flight, in_acc, !in_i.ready, "second packet taken in flight")

endmodule

// File: tb/tb_bitrate_meter_hysteresis_switch.sv
`timescale 1ns / 100ps
// Self-checking bench for the bit-rate meter with hysteresis switch: a probe table, then
// randomized packet streams under several register settings, with a byte burst at one stamp.
// Depends on brm_pkg, brm_stream_if and the bitrate_meter_hysteresis_switch RTL.
module tb_bitrate_meter_hysteresis_switch;
  import brm_pkg::*;

  localparam int unsigned SPAN_TICKS      = 90000;
  localparam longint unsigned KBPS_NUM    = 5625;
  localparam longint unsigned KBPS_DEN    = 8;
  localparam int unsigned PROBE_ROWS      = 17;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 175;
  localparam int unsigned SAT_BEATS       = 40;
  localparam int unsigned DRAIN_PAUSE     = 4;
  localparam int unsigned TAIL_CYCLES     = 64;
  localparam int unsigned CYCLE_LIMIT     = 2000000;

  typedef struct {
    in_item_t  beat;
    bit        typed;
    out_item_t want;
  } probe_row_t;

  typedef struct packed {
    logic [TGT_W-1:0]  tgt;
    logic [FMT_W-1:0]  fmt;
    logic [HOLD_W-1:0] hold;
  } meter_setting_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  brm_stream_if #(.T(in_item_t))  pkt_if ();
  brm_stream_if #(.T(out_item_t)) res_if ();
  brm_stream_if #(.T(cfg_wr_t))   cfg_if ();

  bitrate_meter_hysteresis_switch dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pkt_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // register copies
  logic [TGT_W-1:0]  tgt_kbps;
  logic [FMT_W-1:0]  line_fmt;
  logic [HOLD_W-1:0] hold_cnt;

  // meter state
  logic [SEQ_W-1:0]    last_seq;
  logic [TS_W-1:0]     last_stamp;
  logic [TS_W-1:0]     win_start;
  logic [TS_W-1:0]     win_end;
  logic [BYTES_W-1:0]  win_bytes;
  logic [STREAK_W-1:0] qual_run;
  logic                active_q;

  out_item_t   result_queue [$];
  in_item_t    last_sent;
  bit          gaps_on = 1'b1;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;

  function automatic out_item_t meter_predict(input in_item_t beat);
    out_item_t       res;
    logic [TS_W-1:0] span;
    longint unsigned num;
    longint unsigned den;
    longint unsigned sum;
    longint unsigned r10;
    logic [31:0]     rate;
    logic            hit;
    res  = '0;
    rate = '0;
    if (beat.seq_num == last_seq && beat.timestamp == last_stamp) begin
      res.duplicate = 1'b1;
    end else begin
      span       = win_end - win_start;
      last_seq   = beat.seq_num;
      last_stamp = beat.timestamp;
      if (win_start != 0 && win_end != 0 && span > SPAN_TICKS) begin
        num       = longint'(win_bytes) * KBPS_NUM;
        den       = longint'(span) * KBPS_DEN;
        rate      = 32'(num / den);
        win_bytes = BYTES_W'(beat.payload_len);
        win_start = beat.timestamp;
        win_end   = beat.timestamp;
      end else begin
        sum       = longint'(win_bytes) + longint'(beat.payload_len);
        win_bytes = (sum > 64'hFFFF_FFFF) ? '1 : BYTES_W'(sum);
        if (win_start == 0) win_start = beat.timestamp;
        win_end = beat.timestamp;
      end
      // zero-rate report restarts the window but leaves the switch alone
      if (rate != 0) begin
        if (beat.payload_format != line_fmt) begin
          active_q = 1'b1;
        end else begin
          r10 = longint'(rate) * 10;
          if (active_q) hit = (r10 <= longint'(tgt_kbps) * 9);
          else hit = (r10 >= longint'(tgt_kbps) * 11);
          if (hit) begin
            if (qual_run != '1) qual_run = qual_run + 1'b1;
          end else begin
            qual_run = '0;
          end
          // streak survives a toggle
          if (qual_run >= hold_cnt) active_q = ~active_q;
        end
      end
    end
    res.rate_valid = (rate != 0);
    res.rate_kbps  = rate;
    res.active     = active_q;
    return res;
  endfunction

  task automatic send_packet(input in_item_t beat, input bit typed, input out_item_t want);
    out_item_t guess;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      pkt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    pkt_if.valid   <= 1'b1;
    pkt_if.payload <= beat;
    @(posedge clk_i);
    while (!pkt_if.ready) @(posedge clk_i);
    guess     = meter_predict(beat);
    last_sent = beat;
    result_queue.push_back(typed ? want : guess);
  endtask

  task automatic cfg_beat(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid         <= 1'b1;
    cfg_if.payload.index <= idx;
    cfg_if.payload.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      CFG_TARGET:   tgt_kbps = data[TGT_W-1:0];
      CFG_LINE_FMT: line_fmt = data[FMT_W-1:0];
      CFG_HOLD:     hold_cnt = data[HOLD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input meter_setting_t s);
    cfg_beat(CFG_TARGET, CFG_DATA_W'(s.tgt));
    cfg_beat(CFG_LINE_FMT, CFG_DATA_W'(s.fmt));
    cfg_beat(CFG_HOLD, CFG_DATA_W'(s.hold));
    cfg_if.valid <= 1'b0;
  endtask

  // result side: compare against the oldest expectation, then drive random stalls
  always @(posedge clk_i) begin
    out_item_t seen;
    out_item_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        seen = res_if.payload;
        if (result_queue.size() == 0) begin
          $error("result beat with no packet outstanding");
          err_count++;
        end else begin
          want = result_queue.pop_front();
          if (seen.duplicate !== want.duplicate) begin
            $error("duplicate: expected %0d, got %0d", want.duplicate, seen.duplicate);
            err_count++;
          end
          if (seen.rate_valid !== want.rate_valid) begin
            $error("rate_valid: expected %0d, got %0d", want.rate_valid, seen.rate_valid);
            err_count++;
          end
          if (seen.rate_kbps !== want.rate_kbps) begin
            $error("rate_kbps: expected %0d, got %0d", want.rate_kbps, seen.rate_kbps);
            err_count++;
          end
          if (seen.active !== want.active) begin
            $error("active: expected %0d, got %0d", want.active, seen.active);
            err_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        res_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left   <= $urandom_range(0, 5);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[bitrate_meter_hysteresis_switch] ERROR");
      $finish;
    end
  end

  initial begin
    probe_row_t      probe_rows [PROBE_ROWS];
    meter_setting_t  plan [5];
    meter_setting_t  cur_set;
    in_item_t        beat;
    logic [SEQ_W-1:0] run_seq;
    logic [TS_W-1:0] run_ts;
    logic [TS_W-1:0] run_step;
    logic [TS_W-1:0] sat_ts;
    int unsigned     run_pct;
    int unsigned     seg_left;
    int unsigned     kind;
    longint unsigned lenw;

    rst_ni          = 1'b0;
    pkt_if.valid    = 1'b0;
    pkt_if.payload  = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.payload  = '0;
    res_if.ready    = 1'b0;
    tgt_kbps   = '0;
    line_fmt   = '0;
    hold_cnt   = HOLD_RESET;
    last_seq   = '0;
    last_stamp = '0;
    win_start  = '0;
    win_end    = '0;
    win_bytes  = '0;
    qual_run   = '0;
    active_q   = 1'b0;

    // runs under reset settings: target 0, line format 0, hold 5
    probe_rows = '{
      // seq 0 / stamp 0 matches the cleared history
      '{'{16'h0000, 32'h0000_0000, 16'h0000, 8'h00}, 1'b1, '{1'b1, 1'b0, 32'd0, 1'b0}},
      '{'{16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF}, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b0}},
      '{'{16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF}, 1'b1, '{1'b1, 1'b0, 32'd0, 1'b0}},
      // window crosses the stamp wrap
      '{'{16'h0001, 32'h0000_FFFF, 16'hFFFF, 8'h00}, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b0}},
      '{'{16'h0002, 32'h0002_0000, 16'd1000, 8'h00}, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b0}},
      // report with a foreign format forces active
      '{'{16'h0003, 32'h0003_0000, 16'd5, 8'h80}, 1'b0, '0},
      '{'{16'h0004, 32'h0003_0000, 16'd0, 8'h00}, 1'b0, '0},
      // span of exactly 90000 must not close, 90001 must
      '{'{16'h0005, 32'h0004_5F90, 16'd0, 8'h00}, 1'b0, '0},
      '{'{16'h0006, 32'h0004_5F91, 16'd0, 8'h00}, 1'b0, '0},
      '{'{16'h0007, 32'h0005_0000, 16'd0, 8'h00}, 1'b0, '0},
      '{'{16'h0008, 32'h0007_0000, 16'd40000, 8'h00}, 1'b0, '0},
      // restart lands on stamp 0, next packet re-arms the window
      '{'{16'h0009, 32'h0000_0000, 16'd300, 8'h00}, 1'b0, '0},
      '{'{16'h000A, 32'h0000_0100, 16'd10, 8'h00}, 1'b0, '0},
      '{'{16'h000B, 32'h0002_4AF0, 16'hFFFF, 8'h00}, 1'b0, '0},
      '{'{16'h000C, 32'h0004_0000, 16'd1, 8'hFF}, 1'b0, '0},
      '{'{16'h000C, 32'h0004_0000, 16'h1234, 8'h00}, 1'b0, '0},
      '{'{16'h000C, 32'h0004_0001, 16'd0, 8'h00}, 1'b0, '0}
    };

    plan = '{
      '{20'd800,    8'h21, 4'd1},
      '{20'hFFFFF,  8'hFF, 4'd15},
      '{20'd0,      8'h00, 4'd3},
      '{20'd400,    8'h60, 4'd15},
      '{20'd1000,   8'h5A, 4'd0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < PROBE_ROWS; r++) begin
      send_packet(probe_rows[r].beat, probe_rows[r].typed, probe_rows[r].want);
    end
    pkt_if.valid <= 1'b0;

    run_seq  = 16'h0100;
    run_ts   = 32'h0010_0000;
    run_step = 32'd30000;
    run_pct  = 100;
    seg_left = 0;

    for (int ph = 0; ph < PHASES; ph++) begin
      while (result_queue.size() != 0) @(posedge clk_i);
      repeat (DRAIN_PAUSE) @(posedge clk_i);
      if (ph < 5) cur_set = plan[ph];
      else cur_set = '{TGT_W'($urandom_range(100, 1300)), FMT_W'($urandom),
                       HOLD_W'($urandom_range(1, 15))};
      write_settings(cur_set);
      gaps_on = (ph != PHASES - 1);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(4, 60);
          case ($urandom_range(0, 5))
            0: run_pct = 60;
            1: run_pct = 75;
            2: run_pct = 85;
            3: run_pct = 95;
            4: run_pct = 105;
            default: run_pct = 120;
          endcase
          run_step = $urandom_range(12000, 46000);
        end
        seg_left--;
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          // steady stream sized to land near the target rate
          run_seq = run_seq + 1'b1;
          run_ts  = run_ts + run_step + $urandom_range(0, 500);
          lenw    = longint'(tgt_kbps) * run_pct * run_step / 70300;
          if (lenw == 0) lenw = $urandom_range(0, 3000);
          if (lenw > 65535) lenw = 65535;
          beat.seq_num        = run_seq;
          beat.timestamp      = run_ts;
          beat.payload_len    = LEN_W'(lenw);
          beat.payload_format = ($urandom_range(0, 19) == 0) ? FMT_W'($urandom) : line_fmt;
        end else if (kind < 87) begin
          beat = last_sent;
          beat.payload_len    = LEN_W'($urandom);
          beat.payload_format = FMT_W'($urandom);
        end else if (kind < 95) begin
          beat = {SEQ_W'($urandom), TS_W'($urandom), LEN_W'($urandom), FMT_W'($urandom)};
        end else begin
          // stream jump: near the wrap, onto stamp 0, or anywhere
          run_seq = SEQ_W'($urandom);
          case ($urandom_range(0, 2))
            0: run_ts = 32'hFFFF_FFFF - $urandom_range(0, 100000);
            1: run_ts = '0;
            default: run_ts = $urandom;
          endcase
          beat = '{run_seq, run_ts, LEN_W'($urandom), line_fmt};
        end
        send_packet(beat, 1'b0, '0);
      end

      if (ph == 1) begin
        // pile up full-size packets at one stamp, then close the window
        gaps_on = 1'b0;
        sat_ts  = 32'h1000_0000;
        for (int n = 0; n < SAT_BEATS; n++) begin
          run_seq = run_seq + 1'b1;
          send_packet('{run_seq, sat_ts, 16'hFFFF, line_fmt}, 1'b0, '0);
        end
        run_seq = run_seq + 1'b1;
        send_packet('{run_seq, sat_ts + 32'd90001, 16'hFFFF, line_fmt}, 1'b0, '0);
        run_seq = run_seq + 1'b1;
        run_ts  = sat_ts + 32'd180002;
        send_packet('{run_seq, run_ts, 16'd0, line_fmt}, 1'b0, '0);
        gaps_on = 1'b1;
      end
      pkt_if.valid <= 1'b0;
    end

    while (result_queue.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[bitrate_meter_hysteresis_switch] OK");
    end else begin
      $display("[bitrate_meter_hysteresis_switch] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/brm_pkg.sv
rtl/brm_stream_if.sv
rtl/brm_mul.sv
rtl/brm_div.sv
rtl/brm_hyst.sv
rtl/bitrate_meter_hysteresis_switch.sv
tb/tb_bitrate_meter_hysteresis_switch.sv
